@@ rtl/core/hhs_pkg.sv @@
// shared constants and types for the hashed handle set
`timescale 1ns / 1ps

package hhs_pkg;

	// sizing of the list and the hint table (hint slots must be a power of two)
	localparam int MAX_ENTRIES = 256;
	localparam int HINT_SLOTS  = 1024;
	localparam int HASH_SHIFT  = 6;

	localparam int IDX_W   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CNT_W   = $clog2(MAX_ENTRIES + 1);
	localparam int SLOT_W  = $clog2(HINT_SLOTS);
	localparam int EPOCH_W = 4;

	localparam int HANDLE_W    = 32;
	localparam int PRIO_W      = 8;
	localparam int INDEX_OUT_W = 8;
	localparam int COUNT_OUT_W = 9;

	typedef enum logic {
		OP_ADD   = 1'b0,
		OP_CLEAR = 1'b1
	} op_t;

	typedef struct packed {
		op_t                 operation;
		logic [HANDLE_W-1:0] handle;
		logic [PRIO_W-1:0]   priority_req;
	} req_t;

	typedef struct packed {
		logic [INDEX_OUT_W-1:0] entry_index;
		logic                   already_present;
		logic [PRIO_W-1:0]      merged_priority;
		logic                   list_full;
		logic [COUNT_OUT_W-1:0] entry_count;
	} rsp_t;

	// one hint slot: valid flag, clear epoch it was written in, list position
	typedef struct packed {
		logic               valid;
		logic [EPOCH_W-1:0] epoch;
		logic [IDX_W-1:0]   index;
	} hint_t;

	localparam int HINT_W = $bits(hint_t);

	typedef enum logic [2:0] {
		ST_SWEEP,
		ST_IDLE,
		ST_HINT_RD,
		ST_HINT_CHK,
		ST_VERIFY,
		ST_SCAN,
		ST_DONE
	} state_t;

endpackage

@@ rtl/core/hhs_ram.sv @@
// generic single-write, single-read memory with registered read data
`timescale 1ns / 1ps

module hhs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                        clk,
	input  logic                                        we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                            wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                            rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

@@ rtl/core/hashed_handle_set_with_priority.sv @@
// top level of the deduplicating handle list with priority merge and hash hints
`timescale 1ns / 1ps

// Usage
// Request channel (req_valid / req_stall / req) carries one word per command:
// add a handle with a priority, or clear the whole list. Response channel
// (rsp_valid / rsp_stall / rsp) returns exactly one word per command.
// The block works on one command at a time; req_stall is high while it does.
// An add reads the hint slot of its handle: an empty slot means a new handle,
// which is appended; a slot that points at the handle is checked and merged;
// a stale hint, or one pointing past the end, falls back to a linear scan
// over the stores. A clear empties the list and sweeps the hint table when
// the clear epoch wraps.
// The scan reads one stored handle a cycle through the store memory port.
// After reset the hint table is swept empty, one slot a cycle; req_stall
// stays high during that sweep.
// The response sits in an output register; while rsp_stall is high it holds,
// and the next command may still be accepted and worked on up to its result.
module hashed_handle_set_with_priority
	import hhs_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	state_t state_q, state_d;

	// latched command
	logic [HANDLE_W-1:0] handle_q;
	logic [PRIO_W-1:0]   prio_q;
	logic [SLOT_W-1:0]   slot_q;

	logic [CNT_W-1:0]   count_q;
	logic [EPOCH_W-1:0] epoch_q;
	logic [SLOT_W-1:0]  sweep_q;
	logic               sweep_rsp_q;
	logic [IDX_W-1:0]   pos_q;
	logic [CNT_W-1:0]   scan_q;
	logic [IDX_W-1:0]   cmp_idx_q;
	logic               cmp_valid_q;
	rsp_t               res_q;
	rsp_t               rsp_q;
	logic               rsp_valid_q;

	// memory ports
	logic                hint_we;
	logic [SLOT_W-1:0]   hint_waddr;
	hint_t               hint_wdata;
	logic [SLOT_W-1:0]   hint_raddr;
	hint_t               hint_rd;
	logic                handle_we;
	logic                prio_we;
	logic [IDX_W-1:0]    st_waddr;
	logic [PRIO_W-1:0]   prio_wdata;
	logic [IDX_W-1:0]    st_raddr;
	logic [HANDLE_W-1:0] handle_rd;
	logic [PRIO_W-1:0]   prio_rd;

	// decoded events
	logic              accept;
	logic              out_free;
	logic              hint_hit;
	logic              hint_in_range;
	logic              handle_match;
	logic              found_now;
	logic              miss_now;
	logic              scan_start;
	logic              scan_issue;
	logic              wrap_clear;
	logic              sweep_last;
	logic [IDX_W-1:0]  found_pos;
	logic [PRIO_W-1:0] merged_prio;
	logic [CNT_W-1:0]  count_inc;
	logic              list_is_full;
	logic [HANDLE_W-1:0] handle_shifted;

	assign accept        = req_valid && !req_stall;
	assign out_free      = !rsp_valid_q || !rsp_stall;
	assign hint_hit      = hint_rd.valid && (hint_rd.epoch == epoch_q);
	assign hint_in_range = CNT_W'(hint_rd.index) < count_q;
	assign handle_match  = handle_rd == handle_q;
	assign wrap_clear    = epoch_q == {EPOCH_W{1'b1}};
	assign sweep_last    = sweep_q == SLOT_W'(HINT_SLOTS - 1);
	assign count_inc     = count_q + CNT_W'(1);
	assign list_is_full  = count_q == CNT_W'(MAX_ENTRIES);
	assign merged_prio   = (prio_q > prio_rd) ? prio_q : prio_rd;
	assign handle_shifted = req.handle >> HASH_SHIFT;

	assign req_stall = state_q != ST_IDLE;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// memories
	hhs_ram #(.WIDTH(HINT_W), .DEPTH(HINT_SLOTS)) u_hint_ram (
		.clk   (clk),
		.we    (hint_we),
		.waddr (hint_waddr),
		.wdata (hint_wdata),
		.raddr (hint_raddr),
		.rdata (hint_rd)
	);

	hhs_ram #(.WIDTH(HANDLE_W), .DEPTH(MAX_ENTRIES)) u_handle_ram (
		.clk   (clk),
		.we    (handle_we),
		.waddr (st_waddr),
		.wdata (handle_q),
		.raddr (st_raddr),
		.rdata (handle_rd)
	);

	hhs_ram #(.WIDTH(PRIO_W), .DEPTH(MAX_ENTRIES)) u_prio_ram (
		.clk   (clk),
		.we    (prio_we),
		.waddr (st_waddr),
		.wdata (prio_wdata),
		.raddr (st_raddr),
		.rdata (prio_rd)
	);

	// sequencer outputs and memory control
	always_comb begin
		found_now  = 1'b0;
		miss_now   = 1'b0;
		scan_start = 1'b0;
		scan_issue = 1'b0;
		found_pos  = pos_q;
		hint_raddr = slot_q;
		hint_we    = 1'b0;
		hint_waddr = slot_q;
		hint_wdata = '0;
		st_raddr   = pos_q;
		handle_we  = 1'b0;
		prio_we    = 1'b0;
		st_waddr   = count_q[IDX_W-1:0];
		prio_wdata = prio_q;
		case (state_q)
			ST_SWEEP: begin
				hint_we    = 1'b1;
				hint_waddr = sweep_q;
			end
			ST_HINT_CHK: begin
				st_raddr = hint_rd.index;
				if (!hint_hit) begin
					miss_now = 1'b1;
				end else if (!hint_in_range) begin
					scan_start = 1'b1;
				end
			end
			ST_VERIFY: begin
				if (handle_match) begin
					found_now = 1'b1;
				end else begin
					scan_start = 1'b1;
				end
			end
			ST_SCAN: begin
				st_raddr = scan_q[IDX_W-1:0];
				if (cmp_valid_q && handle_match) begin
					found_now  = 1'b1;
					found_pos  = cmp_idx_q;
					hint_we    = 1'b1;
					hint_wdata = '{valid: 1'b1, epoch: epoch_q, index: cmp_idx_q};
				end else if (scan_q < count_q) begin
					scan_issue = 1'b1;
				end else begin
					miss_now = 1'b1;
				end
			end
			default: begin
			end
		endcase
		// priority merge on a hit
		if (found_now) begin
			st_waddr = found_pos;
			prio_we  = prio_q > prio_rd;
		end
		// append of a new handle
		if (miss_now && !list_is_full) begin
			handle_we  = 1'b1;
			prio_we    = 1'b1;
			hint_we    = 1'b1;
			hint_wdata = '{valid: 1'b1, epoch: epoch_q, index: count_q[IDX_W-1:0]};
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_SWEEP: begin
				if (sweep_last) begin
					state_d = sweep_rsp_q ? ST_DONE : ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					if (req.operation == OP_CLEAR) begin
						state_d = wrap_clear ? ST_SWEEP : ST_DONE;
					end else begin
						state_d = ST_HINT_RD;
					end
				end
			end
			ST_HINT_RD: state_d = ST_HINT_CHK;
			ST_HINT_CHK: begin
				if (miss_now) begin
					state_d = ST_DONE;
				end else if (scan_start) begin
					state_d = ST_SCAN;
				end else begin
					state_d = ST_VERIFY;
				end
			end
			ST_VERIFY: state_d = found_now ? ST_DONE : ST_SCAN;
			ST_SCAN: begin
				if (found_now || miss_now) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_SWEEP;
			count_q     <= '0;
			epoch_q     <= '0;
			sweep_q     <= '0;
			sweep_rsp_q <= 1'b0;
			cmp_valid_q <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_SWEEP) begin
				sweep_q <= sweep_q + SLOT_W'(1);
			end
			// clear: bump the epoch, or sweep the table when it wraps
			if (accept && req.operation == OP_CLEAR) begin
				count_q <= '0;
				if (wrap_clear) begin
					epoch_q     <= '0;
					sweep_q     <= '0;
					sweep_rsp_q <= 1'b1;
				end else begin
					epoch_q <= epoch_q + EPOCH_W'(1);
				end
			end
			if (miss_now && !list_is_full) begin
				count_q <= count_inc;
			end
			if (scan_start) begin
				cmp_valid_q <= 1'b0;
			end else if (state_q == ST_SCAN) begin
				cmp_valid_q <= scan_issue;
			end
			// output register
			if (state_q == ST_DONE && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			handle_q <= req.handle;
			prio_q   <= req.priority_req;
			slot_q   <= handle_shifted[SLOT_W-1:0];
			res_q    <= '0;
		end
		if (state_q == ST_HINT_CHK) begin
			pos_q <= hint_rd.index;
		end
		// scan address walk
		if (scan_start) begin
			scan_q <= '0;
		end else if (scan_issue) begin
			scan_q    <= scan_q + CNT_W'(1);
			cmp_idx_q <= scan_q[IDX_W-1:0];
		end
		// result word
		if (found_now) begin
			res_q.entry_index     <= INDEX_OUT_W'(found_pos);
			res_q.already_present <= 1'b1;
			res_q.merged_priority <= merged_prio;
			res_q.list_full       <= 1'b0;
			res_q.entry_count     <= COUNT_OUT_W'(count_q);
		end else if (miss_now) begin
			res_q.already_present <= 1'b0;
			if (list_is_full) begin
				res_q.entry_index     <= '0;
				res_q.merged_priority <= '0;
				res_q.list_full       <= 1'b1;
				res_q.entry_count     <= COUNT_OUT_W'(count_q);
			end else begin
				res_q.entry_index     <= INDEX_OUT_W'(count_q);
				res_q.merged_priority <= prio_q;
				res_q.list_full       <= 1'b0;
				res_q.entry_count     <= COUNT_OUT_W'(count_inc);
			end
		end
		if (state_q == ST_DONE && out_free) begin
			rsp_q <= res_q;
		end
	end

endmodule

@@ bench/hhs_checker.sv @@
// checker for the hashed handle set: mirrors the list and compares every response word
`timescale 1ns / 1ps

module hhs_checker
	import hhs_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	input  logic req_stall,
	input  req_t req,
	input  logic rsp_valid,
	input  logic rsp_stall,
	input  rsp_t rsp,
	output int   fail_count,
	output int   words_owed
);

	// mirror of the hint slots and the stored entries
	bit                  slot_live   [HINT_SLOTS];
	int                  slot_entry  [HINT_SLOTS];
	logic [HANDLE_W-1:0] kept_handle [MAX_ENTRIES];
	logic [PRIO_W-1:0]   kept_prio   [MAX_ENTRIES];
	int                  kept_count;

	// responses owed by the block, oldest first
	rsp_t owed_rsp [$];
	rsp_t want;

	// apply one command word to the mirror and return the response it owes
	function automatic rsp_t mirror_apply(input req_t c);
		rsp_t r;
		int   s;
		int   pos;
		bit   hit;
		r   = '0;
		pos = 0;
		hit = 1'b0;
		if (c.operation == OP_CLEAR) begin
			for (int k = 0; k < HINT_SLOTS; k++)
				slot_live[k] = 1'b0;
			kept_count = 0;
			return r;
		end
		s = int'((c.handle >> HASH_SHIFT) % HINT_SLOTS);
		// hint lookup; a stale slot falls back to an in-order search
		if (slot_live[s]) begin
			if (slot_entry[s] < kept_count && kept_handle[slot_entry[s]] == c.handle) begin
				hit = 1'b1;
				pos = slot_entry[s];
			end else begin
				for (int i = 0; i < kept_count; i++) begin
					if (!hit && kept_handle[i] == c.handle) begin
						hit           = 1'b1;
						pos           = i;
						slot_entry[s] = i;
					end
				end
			end
		end
		// merge the priority, drop on a full list, or append
		if (hit) begin
			if (c.priority_req > kept_prio[pos])
				kept_prio[pos] = c.priority_req;
			r.entry_index     = INDEX_OUT_W'(pos);
			r.already_present = 1'b1;
			r.merged_priority = kept_prio[pos];
		end else if (kept_count >= MAX_ENTRIES) begin
			r.list_full = 1'b1;
		end else begin
			kept_handle[kept_count] = c.handle;
			kept_prio[kept_count]   = c.priority_req;
			slot_entry[s]           = kept_count;
			slot_live[s]            = 1'b1;
			r.entry_index           = INDEX_OUT_W'(kept_count);
			r.merged_priority       = c.priority_req;
			kept_count++;
		end
		r.entry_count = COUNT_OUT_W'(kept_count);
		return r;
	endfunction

	// one field of a response word
	task automatic compare_field(input string what, input logic [31:0] exp_val,
			input logic [31:0] got_val);
		if (got_val !== exp_val) begin
			fail_count++;
			if (fail_count <= 10)
				$display("%t mismatch in %s: expected %0h, got %0h",
					$time, what, exp_val, got_val);
		end
	endtask

	// watch both channels
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < HINT_SLOTS; k++) begin
				slot_live[k]  = 1'b0;
				slot_entry[k] = 0;
			end
			for (int k = 0; k < MAX_ENTRIES; k++) begin
				kept_handle[k] = '0;
				kept_prio[k]   = '0;
			end
			kept_count = 0;
			owed_rsp.delete();
			words_owed = 0;
			fail_count = 0;
		end else begin
			// response side first, so a stray word never meets the command taken now
			if (rsp_valid && !rsp_stall) begin
				if (owed_rsp.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%t response word with nothing owed: %h", $time, rsp);
				end else begin
					want = owed_rsp.pop_front();
					compare_field("entry_index", 32'(want.entry_index),
						32'(rsp.entry_index));
					compare_field("already_present", 32'(want.already_present),
						32'(rsp.already_present));
					compare_field("merged_priority", 32'(want.merged_priority),
						32'(rsp.merged_priority));
					compare_field("list_full", 32'(want.list_full),
						32'(rsp.list_full));
					compare_field("entry_count", 32'(want.entry_count),
						32'(rsp.entry_count));
				end
			end
			if (req_valid && !req_stall)
				owed_rsp.push_back(mirror_apply(req));
			words_owed = owed_rsp.size();
		end
	end

endmodule

@@ bench/tb_top.sv @@
// testbench top for the hashed handle set: clock, reset, command stimulus, verdict
`timescale 1ns / 1ps

module tb_top;
	import hhs_pkg::*;

	// bits 15..6 of a handle pick its hint slot
	localparam logic [HANDLE_W-1:0] SLOT_BITS = HANDLE_W'(HINT_SLOTS - 1) << HASH_SHIFT;

	logic clk = 1'b0;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp;
	int   fail_count;
	int   words_owed;

	// stimulus bookkeeping
	logic [HANDLE_W-1:0] live_handles [$];
	int                  words_sent;
	bit                  calm;
	bit                  idle_on;
	bit                  hold_off_req;

	hashed_handle_set_with_priority dut (
		.clk,
		.arst_n,
		.req_valid,
		.req_stall,
		.req,
		.rsp_valid,
		.rsp_stall,
		.rsp
	);

	hhs_checker chk (
		.clk,
		.arst_n,
		.req_valid,
		.req_stall,
		.req,
		.rsp_valid,
		.rsp_stall,
		.rsp,
		.fail_count,
		.words_owed
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// reset once
	initial begin
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// response side: random stall bursts, one long hold-off on request
	initial begin
		rsp_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				rsp_stall <= 1'b1;
				repeat (300) @(negedge clk);
				rsp_stall <= 1'b0;
			end else if (!calm && idle_on && $urandom_range(0, 7) == 0) begin
				rsp_stall <= 1'b1;
				repeat ($urandom_range(1, 19)) @(negedge clk);
				rsp_stall <= 1'b0;
			end
		end
	end

	// present one command word and hold it until the block takes it
	task automatic put_word(input req_t w);
		req       <= w;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		@(negedge clk);
		words_sent++;
	endtask

	// send a word, track the handles in the list, then maybe go quiet a while
	task automatic offer_word(input op_t op, input logic [HANDLE_W-1:0] h,
			input logic [PRIO_W-1:0] p);
		req_t w;
		w.operation    = op;
		w.handle       = h;
		w.priority_req = p;
		put_word(w);
		if (op == OP_CLEAR)
			live_handles.delete();
		else if (live_handles.size() < 300)
			live_handles.push_back(h);
		if (!calm && idle_on && $urandom_range(0, 4) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(negedge clk);
		end
	endtask

	// fresh handle, one already added, or one sharing a hint slot with one added
	function automatic logic [HANDLE_W-1:0] pick_handle();
		int                  roll;
		logic [HANDLE_W-1:0] base;
		roll = $urandom_range(0, 99);
		if (live_handles.size() == 0 || roll < 35)
			return $urandom;
		base = live_handles[$urandom_range(0, live_handles.size() - 1)];
		if (roll < 70)
			return base;
		// same slot bits, other bits changed, so the hint goes stale
		return base ^ ($urandom & ~SLOT_BITS);
	endfunction

	// stimulus
	initial begin
		int seq;
		int len;
		req_valid    = 1'b0;
		req          = '0;
		calm         = 1'b0;
		idle_on      = 1'b1;
		hold_off_req = 1'b0;
		words_sent   = 0;
		@(posedge arst_n);
		@(negedge clk);

		// directed: extremes, priority merge both ways, stale hints, clears
		offer_word(OP_ADD, 32'h0000_0000, 8'd0);
		offer_word(OP_ADD, 32'h0000_0000, 8'd255);
		offer_word(OP_ADD, 32'h0000_0000, 8'd7);
		offer_word(OP_ADD, 32'hFFFF_FFFF, 8'd255);
		offer_word(OP_ADD, 32'hFFFF_FFFF, 8'd0);
		// same slot as handle zero: hint stale, search misses, hint moves
		offer_word(OP_ADD, 32'h0001_0000, 8'd10);
		// hint now points elsewhere: search finds the older entry
		offer_word(OP_ADD, 32'h0000_0000, 8'd1);
		offer_word(OP_ADD, 32'h0001_0000, 8'd200);
		offer_word(OP_ADD, 32'h0000_003F, 8'd5);
		offer_word(OP_ADD, 32'hAAAA_AAAA, 8'hAA);
		offer_word(OP_ADD, 32'h5555_5555, 8'h55);
		offer_word(OP_ADD, 32'hAAAA_AAAA, 8'h55);
		offer_word(OP_CLEAR, 32'hFFFF_FFFF, 8'd255);
		offer_word(OP_ADD, 32'h0000_0000, 8'd3);
		offer_word(OP_ADD, 32'hFFFF_FFFF, 8'd128);
		offer_word(OP_CLEAR, 32'h0000_0000, 8'd0);
		offer_word(OP_CLEAR, 32'h1234_5678, 8'd9);
		offer_word(OP_ADD, 32'h1234_5678, 8'd1);
		offer_word(OP_ADD, 32'hFFFF_FFFF, 8'd254);

		// random: each run starts from a clear; two of them fill the list past its end
		seq = 0;
		while (words_sent < 1650) begin
			idle_on = ($urandom_range(0, 3) != 0);
			if (words_sent > 1450)
				calm = 1'b1;
			if (seq == 2)
				hold_off_req = 1'b1;
			offer_word(OP_CLEAR, $urandom, PRIO_W'($urandom));
			if (seq == 0 || seq == 20) begin
				repeat (MAX_ENTRIES) offer_word(OP_ADD, $urandom, PRIO_W'($urandom));
				repeat (16) offer_word(OP_ADD, pick_handle(), PRIO_W'($urandom));
			end else begin
				len = $urandom_range(4, 60);
				repeat (len) begin
					if ($urandom_range(0, 24) == 0)
						offer_word(OP_CLEAR, $urandom, PRIO_W'($urandom));
					else
						offer_word(OP_ADD, pick_handle(), PRIO_W'($urandom));
				end
			end
			seq++;
		end

		// drain, then give stray words time to show up
		req_valid <= 1'b0;
		while (words_owed != 0) @(negedge clk);
		repeat (300) @(negedge clk);
		if (fail_count == 0 && words_owed == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// run limit
	initial begin
		#20_000_000;
		$display("== FAIL ==");
		$finish;
	end

endmodule

@@ files.f @@
rtl/core/hhs_pkg.sv
rtl/core/hhs_ram.sv
rtl/core/hashed_handle_set_with_priority.sv
bench/hhs_checker.sv
bench/tb_top.sv
